// ===== hw/rtl/hkdm_pkg.sv =====
// Shared constants and types of the hash key duplicate marker.
package hkdm_pkg;

   localparam int KEY_W       = 64;
   localparam int EPOCH_W     = 8;
   localparam int CHUNK_W     = 8;
   localparam int CHUNKS      = KEY_W / CHUNK_W;
   localparam int FOLD_GROW_W = CHUNK_W + $clog2(CHUNKS);
   localparam int BUCKETS_DEF = 1024;
   localparam int WAYS_DEF    = 4;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_FOLD   = 7'b0000100,
      ST_SCALE  = 7'b0001000,
      ST_REDUCE = 7'b0010000,
      ST_READ   = 7'b0100000,
      ST_CMP    = 7'b1000000
   } state_type;

endpackage

// ===== hw/rtl/hash_key_duplicate_marker_top.sv =====
// Top level of the hash key duplicate marker: bucket memory, remainder unit and control.
//
// A key beat is taken at a rising edge where start is high and busy is low; req_new_set
// opens a new set, so that all keys stored before it are forgotten. Each key gives one
// result beat, shown for exactly one cycle with rsp_strobe high: rsp_duplicate is set when
// the key equals an earlier key of the set, rsp_overflow when the key was new but its
// bucket already held WAYS keys, so it could not be stored.
// The bucket is the key modulo BUCKETS. With BUCKETS a power of two it is a bit-select:
// the key passes through the read and compare states, and busy falls as the result beat
// is shown, so the next key beat can be taken while rsp_strobe is high. Otherwise a remainder
// unit adds three steps: it sums the key's bytes weighted by their place values modulo
// BUCKETS, multiplies the sum by a scaled reciprocal of BUCKETS and subtracts the quotient
// times BUCKETS, before the read and compare states.
// Each bucket is one row of a single-port-read, single-port-write memory holding its keys,
// a valid bit per way and a set number; a row whose set number differs from the current
// one reads as empty, so opening a new set costs nothing. After reset, and when the
// 8-bit set number wraps at a new set, a clearing pass writes every row, one a cycle,
// while busy stays high.
// The receiver cannot stall; a result beat is presented exactly once.
module hash_key_duplicate_marker_top #(
   parameter int BUCKETS = hkdm_pkg::BUCKETS_DEF,
   parameter int WAYS    = hkdm_pkg::WAYS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_new_set,
   input  logic [hkdm_pkg::KEY_W-1:0] req_key,
   output logic                      rsp_strobe,
   output logic                      rsp_duplicate,
   output logic                      rsp_overflow
);

   localparam int  IW       = $clog2(BUCKETS);
   localparam bit  IS_POW2  = (BUCKETS & (BUCKETS - 1)) == 0;
   localparam int  KEYS_W   = WAYS * hkdm_pkg::KEY_W;
   localparam int  ROW_W    = KEYS_W + WAYS + hkdm_pkg::EPOCH_W;
   localparam int  FW       = IW + hkdm_pkg::FOLD_GROW_W;
   localparam int  RW       = FW + 1;
   localparam int  PW       = FW + RW;
   localparam int  QW       = PW - FW - IW;
   localparam longint unsigned BUCKETS_L = 64'(BUCKETS);
   localparam longint unsigned RECIP_L   =
      ((64'd1 << (FW + IW)) + BUCKETS_L - 64'd1) / BUCKETS_L;
   localparam logic [RW-1:0] RECIP      = RW'(RECIP_L);
   localparam logic [FW-1:0] BUCKETS_FW = FW'(BUCKETS);
   localparam logic [IW-1:0] LAST_IDX  = IW'(BUCKETS - 1);
   localparam logic [hkdm_pkg::EPOCH_W-1:0] EPOCH_FIRST = hkdm_pkg::EPOCH_W'(1);
   localparam logic [hkdm_pkg::EPOCH_W-1:0] EPOCH_LAST  = '1;

   function automatic logic [hkdm_pkg::CHUNKS*IW-1:0] fold_weights();
      logic [hkdm_pkg::CHUNKS*IW-1:0] wts;
      longint unsigned                w;
      wts = '0;
      w   = 64'd1;
      for (int c = 0; c < hkdm_pkg::CHUNKS; c++) begin
         wts[c*IW +: IW] = IW'(w);
         for (int s = 0; s < hkdm_pkg::CHUNK_W; s++) begin
            w = w << 1;
            if (w >= BUCKETS_L) begin
               w = w - BUCKETS_L;
            end
         end
      end
      return wts;
   endfunction

   localparam logic [hkdm_pkg::CHUNKS*IW-1:0] WEIGHTS = fold_weights();

   hkdm_pkg::state_type state_ff, state_in;

   logic [IW-1:0]                      clr_idx_ff, clr_idx_in;
   logic                               pend_ff, pend_in;
   logic [hkdm_pkg::EPOCH_W-1:0]       epoch_ff, epoch_in;
   logic [hkdm_pkg::KEY_W-1:0]         key_ff, key_in;
   logic [FW-1:0]                      fold_ff, fold_in;
   logic [PW-1:0]                      prod_ff, prod_in;
   logic [IW-1:0]                      idx_ff, idx_in;
   logic                               strobe_ff, strobe_in;
   logic                               dup_ff, dup_in;
   logic                               ovf_ff, ovf_in;

   logic [ROW_W-1:0]                   mem [BUCKETS];
   logic [ROW_W-1:0]                   rd_data_ff;
   logic                               mem_we;
   logic [IW-1:0]                      mem_waddr;
   logic [ROW_W-1:0]                   mem_wdata;

   logic [FW-1:0]                      fold_sum;
   logic [QW-1:0]                      quot;
   logic [FW-1:0]                      red;
   logic                               row_live;
   logic [WAYS-1:0]                    row_valid;
   logic                               hit;
   logic                               have_free;
   logic [WAYS-1:0]                    new_valid;
   logic [KEYS_W-1:0]                  new_keys;

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      pend_in    = pend_ff;
      epoch_in   = epoch_ff;
      key_in     = key_ff;
      fold_in    = fold_ff;
      prod_in    = prod_ff;
      idx_in     = idx_ff;
      strobe_in  = 1'b0;
      dup_in     = dup_ff;
      ovf_in     = ovf_ff;
      mem_we     = 1'b0;
      mem_waddr  = clr_idx_ff;
      mem_wdata  = '0;

      fold_sum = '0;
      for (int c = 0; c < hkdm_pkg::CHUNKS; c++) begin
         fold_sum = fold_sum
            + FW'(key_ff[c*hkdm_pkg::CHUNK_W +: hkdm_pkg::CHUNK_W])
            * FW'(WEIGHTS[c*IW +: IW]);
      end
      quot = prod_ff[PW-1 -: QW];
      red  = fold_ff - FW'(quot) * BUCKETS_FW;

      row_live  = rd_data_ff[KEYS_W + WAYS +: hkdm_pkg::EPOCH_W] == epoch_ff;
      row_valid = row_live ? rd_data_ff[KEYS_W +: WAYS] : '0;
      hit       = 1'b0;
      have_free = 1'b0;
      new_valid = row_valid;
      new_keys  = rd_data_ff[KEYS_W-1:0];
      for (int w = 0; w < WAYS; w++) begin
         if (row_valid[w]) begin
            if (rd_data_ff[w*hkdm_pkg::KEY_W +: hkdm_pkg::KEY_W] == key_ff) begin
               hit = 1'b1;
            end
         end else if (!have_free) begin
            have_free    = 1'b1;
            new_valid[w] = 1'b1;
            new_keys[w*hkdm_pkg::KEY_W +: hkdm_pkg::KEY_W] = key_ff;
         end
      end

      case (state_ff)
         hkdm_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            if (clr_idx_ff == LAST_IDX) begin
               clr_idx_in = '0;
               pend_in    = 1'b0;
               if (pend_ff) begin
                  state_in = IS_POW2 ? hkdm_pkg::ST_READ : hkdm_pkg::ST_FOLD;
               end else begin
                  state_in = hkdm_pkg::ST_IDLE;
               end
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end
         hkdm_pkg::ST_IDLE: begin
            if (start) begin
               key_in = req_key;
               idx_in = req_key[IW-1:0];
               if (req_new_set && epoch_ff == EPOCH_LAST) begin
                  epoch_in = EPOCH_FIRST;
                  pend_in  = 1'b1;
                  state_in = hkdm_pkg::ST_CLEAR;
               end else begin
                  if (req_new_set) begin
                     epoch_in = epoch_ff + 1'b1;
                  end
                  state_in = IS_POW2 ? hkdm_pkg::ST_READ : hkdm_pkg::ST_FOLD;
               end
            end
         end
         hkdm_pkg::ST_FOLD: begin
            fold_in  = fold_sum;
            state_in = hkdm_pkg::ST_SCALE;
         end
         hkdm_pkg::ST_SCALE: begin
            prod_in  = PW'(fold_ff) * PW'(RECIP);
            state_in = hkdm_pkg::ST_REDUCE;
         end
         hkdm_pkg::ST_REDUCE: begin
            idx_in   = red[IW-1:0];
            state_in = hkdm_pkg::ST_READ;
         end
         hkdm_pkg::ST_READ: begin
            state_in = hkdm_pkg::ST_CMP;
         end
         hkdm_pkg::ST_CMP: begin
            mem_waddr = idx_ff;
            mem_wdata = {epoch_ff, new_valid, new_keys};
            mem_we    = !hit && have_free;
            strobe_in = 1'b1;
            dup_in    = hit;
            ovf_in    = !hit && !have_free;
            state_in  = hkdm_pkg::ST_IDLE;
         end
         default: begin
            state_in = hkdm_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hkdm_pkg::ST_CLEAR;
         clr_idx_ff <= '0;
         pend_ff    <= 1'b0;
         epoch_ff   <= EPOCH_FIRST;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         pend_ff    <= pend_in;
         epoch_ff   <= epoch_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      fold_ff <= fold_in;
      prod_ff <= prod_in;
      idx_ff  <= idx_in;
      dup_ff  <= dup_in;
      ovf_ff  <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == hkdm_pkg::ST_READ) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   assign busy          = state_ff != hkdm_pkg::ST_IDLE;
   assign rsp_strobe    = strobe_ff;
   assign rsp_duplicate = dup_ff;
   assign rsp_overflow  = ovf_ff;

   a_strobe_after_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == hkdm_pkg::ST_CMP))
      else $error("Result beat without a compare cycle.");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_duplicate && rsp_overflow))
      else $error("Result beat flags both duplicate and overflow.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Block not busy after taking a key beat.");

   a_epoch_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff != hkdm_pkg::ST_CLEAR |-> epoch_ff != '0)
      else $error("Set number is zero outside the clearing pass.");

endmodule
